@@ src/rrsd_pkg.sv @@
// Shared types and constants for the round-robin server dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package rrsd_pkg;

	localparam int TIME_W  = 32;
	localparam int END_W   = TIME_W + 1;
	localparam int COUNT_W = 32;
	localparam int CFG_W   = 5;
	localparam int SIDX_W  = 4;

	localparam logic [CFG_W-1:0] NUM_SERVERS_RST = 5'd16;

	typedef enum logic [1:0] {
		KIND_ASSIGN = 2'd0,
		KIND_DROP   = 2'd1,
		KIND_REPORT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PICK,
		ST_MAX,
		ST_RPT
	} state_t;

	// Queue entry between front and back.
	typedef struct packed {
		logic [TIME_W-1:0] arrival;
		logic [END_W-1:0]  end_time;
		logic              last;
	} req_t;

	typedef struct packed {
		kind_t              kind;
		logic [SIDX_W-1:0]  server_index;
		logic [COUNT_W-1:0] handled_count;
		logic               last_result;
	} res_t;

endpackage

`default_nettype wire

@@ src/rrsd_req_if.sv @@
// Request channel: valid/ready plus request payload.
`timescale 1ns / 1ps
`default_nettype none

interface rrsd_req_if;
	import rrsd_pkg::*;

	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] arrival_time;
	logic [TIME_W-1:0] load_time;
	logic              last_request;

	modport source(output valid, output arrival_time, output load_time,
		output last_request, input ready);
	modport sink(input valid, input arrival_time, input load_time,
		input last_request, output ready);
endinterface

`default_nettype wire

@@ src/rrsd_rsp_if.sv @@
// Result channel: valid/ready plus result payload.
`timescale 1ns / 1ps
`default_nettype none

interface rrsd_rsp_if;
	import rrsd_pkg::*;

	logic               valid;
	logic               ready;
	kind_t              kind;
	logic [SIDX_W-1:0]  server_index;
	logic [COUNT_W-1:0] handled_count;
	logic               last_result;

	modport source(output valid, output kind, output server_index,
		output handled_count, output last_result, input ready);
	modport sink(input valid, input kind, input server_index,
		input handled_count, input last_result, output ready);
endinterface

`default_nettype wire

@@ src/rrsd_front.sv @@
// Front end: accepts request beats, computes end time, queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module rrsd_front (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rrsd_req_if.sink    req,
	output logic        q_valid,
	input  wire logic   q_pop,
	output rrsd_pkg::req_t q_head
);
	import rrsd_pkg::*;

	localparam int QD = 2;
	localparam int PW = 1;

	req_t          mem_q [QD];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          push;
	req_t          entry;

	assign req.ready = (cnt_q != (PW+1)'(QD));
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != '0);
	assign q_head    = mem_q[rd_q];

	always_comb begin
		entry.arrival  = req.arrival_time;
		entry.end_time = {1'b0, req.arrival_time} + {1'b0, req.load_time};
		entry.last     = req.last_request;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (q_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ src/rrsd_back.sv @@
// Back end: frees servers, picks the next free one round robin or drops, reports busiest servers.
`timescale 1ns / 1ps
`default_nettype none

module rrsd_back #(
	parameter int MAX_SERVERS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [rrsd_pkg::CFG_W-1:0] num_servers,
	input  wire logic                   q_valid,
	output logic                        q_pop,
	input  wire rrsd_pkg::req_t         q_head,
	rrsd_rsp_if.source                  rsp
);
	import rrsd_pkg::*;

	localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int KW = $clog2(MAX_SERVERS + 1);

	state_t             state_q, state_d;
	logic [END_W-1:0]   item_end_q;
	logic               item_last_q;
	logic [IW-1:0]      sp_q;
	logic [MAX_SERVERS-1:0] busy_q;
	logic [END_W-1:0]   bu_q  [MAX_SERVERS];
	logic [COUNT_W-1:0] cnt_q [MAX_SERVERS];
	logic [IW-1:0]      walk_q, lastidx_q;
	logic [COUNT_W-1:0] top_q;
	logic               out_valid_q;
	res_t               out_q, out_d;

	logic [KW-1:0]      k;
	logic [KW-1:0]      start, start_nxt;
	logic [MAX_SERVERS-1:0] free_hit, free_v, hi_v;
	logic [IW-1:0]      hi_idx, lo_idx, pick_idx, rd_idx;
	logic               hi_f, lo_f, found;
	logic [COUNT_W-1:0] cnt_rd, cnt_inc;
	logic               walk_last, out_free;
	logic               do_free, do_assign, max_step, rpt_step, clear_all, out_load;

	// Servers in use: zero acts as one, above the pool acts as the pool.
	always_comb begin
		if (num_servers == '0) begin
			k = KW'(1);
		end else if (int'(num_servers) > MAX_SERVERS) begin
			k = KW'(MAX_SERVERS);
		end else begin
			k = KW'(num_servers);
		end
	end

	assign start     = (KW'(sp_q) < k) ? KW'(sp_q) : '0;
	assign start_nxt = ((start + KW'(1)) >= k) ? '0 : (start + KW'(1));

	always_comb begin
		for (int i = 0; i < MAX_SERVERS; i++) begin
			free_hit[i] = busy_q[i] && (i < int'(k)) &&
				(bu_q[i] <= {1'b0, q_head.arrival});
			free_v[i]   = !busy_q[i] && (i < int'(k));
			hi_v[i]     = free_v[i] && (i >= int'(start));
		end
	end

	// Circular priority: lowest free at or after start, else lowest free overall.
	always_comb begin
		hi_idx = '0;
		lo_idx = '0;
		hi_f   = 1'b0;
		lo_f   = 1'b0;
		for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
			if (hi_v[i]) begin
				hi_idx = IW'(i);
				hi_f   = 1'b1;
			end
			if (free_v[i]) begin
				lo_idx = IW'(i);
				lo_f   = 1'b1;
			end
		end
	end

	assign pick_idx  = hi_f ? hi_idx : lo_idx;
	assign found     = hi_f || lo_f;
	assign rd_idx    = (state_q == ST_PICK) ? pick_idx : walk_q;
	assign cnt_rd    = cnt_q[rd_idx];
	assign cnt_inc   = (cnt_rd == '1) ? cnt_rd : (cnt_rd + COUNT_W'(1));
	assign walk_last = (KW'(walk_q) == (k - KW'(1)));
	assign out_free  = !out_valid_q || rsp.ready;

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		do_free   = 1'b0;
		do_assign = 1'b0;
		max_step  = 1'b0;
		rpt_step  = 1'b0;
		clear_all = 1'b0;
		out_load  = 1'b0;
		out_d     = out_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					do_free = 1'b1;
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				if (out_free) begin
					do_assign = 1'b1;
					out_load  = 1'b1;
					if (found) begin
						out_d.kind          = KIND_ASSIGN;
						out_d.server_index  = SIDX_W'(pick_idx);
						out_d.handled_count = cnt_inc;
					end else begin
						out_d.kind          = KIND_DROP;
						out_d.server_index  = '0;
						out_d.handled_count = '0;
					end
					out_d.last_result = !item_last_q;
					state_d = item_last_q ? ST_MAX : ST_IDLE;
				end
			end
			ST_MAX: begin
				max_step = 1'b1;
				if (walk_last) begin
					state_d = ST_RPT;
				end
			end
			ST_RPT: begin
				if (out_free) begin
					rpt_step = 1'b1;
					if (cnt_rd == top_q) begin
						out_load            = 1'b1;
						out_d.kind          = KIND_REPORT;
						out_d.server_index  = SIDX_W'(walk_q);
						out_d.handled_count = top_q;
						out_d.last_result   = (walk_q == lastidx_q);
					end
					if (walk_last) begin
						clear_all = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
		if (q_pop) begin
			item_end_q  <= q_head.end_time;
			item_last_q <= q_head.last;
		end
	end

	// Server state: busy flags, busy-until times, handled counts, pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q   <= '0;
			busy_q <= '0;
			for (int i = 0; i < MAX_SERVERS; i++) begin
				bu_q[i]  <= '0;
				cnt_q[i] <= '0;
			end
		end else if (clear_all) begin
			sp_q   <= '0;
			busy_q <= '0;
			for (int i = 0; i < MAX_SERVERS; i++) begin
				bu_q[i]  <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			if (do_free) begin
				busy_q <= busy_q & ~free_hit;
			end
			if (do_assign) begin
				sp_q <= IW'(start_nxt);
				if (found) begin
					busy_q[pick_idx] <= 1'b1;
					bu_q[pick_idx]   <= item_end_q;
					cnt_q[pick_idx]  <= cnt_inc;
				end
			end
		end
	end

	// Report walk: find the top count and the last server holding it, then emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q    <= '0;
			top_q     <= '0;
			lastidx_q <= '0;
		end else begin
			if (do_assign) begin
				walk_q <= '0;
			end else if (max_step || rpt_step) begin
				walk_q <= walk_last ? '0 : (walk_q + IW'(1));
			end
			if (max_step) begin
				if (walk_q == '0 || cnt_rd > top_q) begin
					top_q     <= cnt_rd;
					lastidx_q <= walk_q;
				end else if (cnt_rd == top_q) begin
					lastidx_q <= walk_q;
				end
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.kind          = out_q.kind;
	assign rsp.server_index  = out_q.server_index;
	assign rsp.handled_count = out_q.handled_count;
	assign rsp.last_result   = out_q.last_result;

	a_pick_marks_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK && out_free && found) |=> busy_q[$past(pick_idx)])
		else $error("chosen server not marked busy");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		clear_all |=> (busy_q == '0 && sp_q == '0 && state_q == ST_IDLE))
		else $error("state not cleared after report");

	a_walk_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAX || state_q == ST_RPT) |-> item_last_q)
		else $error("report walk without last request");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten while held");

endmodule

`default_nettype wire

@@ src/round_robin_server_dispatcher.sv @@
// Top level: config register, request front end, dispatch back end.
// A request's dispatch result passes from the queue to the pick unit, then to the result register;
// the pick waits while rsp still holds an earlier result.
// One request at a time: the back end pops it and frees servers, then picks before it pops the next.
// A last request adds a report walk of the N servers in use, one server per cycle when rsp is ready.
// Reset (arst_n low) clears all server state and sets the server count to 16.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_server_dispatcher #(
	parameter int MAX_SERVERS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [rrsd_pkg::CFG_W-1:0] cfg_wdata,
	rrsd_req_if.sink                        req,
	rrsd_rsp_if.source                      rsp
);
	import rrsd_pkg::*;

	logic [CFG_W-1:0] num_q;
	logic             q_valid;
	logic             q_pop;
	req_t             q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NUM_SERVERS_RST;
		end else if (cfg_we) begin
			num_q <= cfg_wdata;
		end
	end

	rrsd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_valid(q_valid),
		.q_pop  (q_pop),
		.q_head (q_head)
	);

	rrsd_back #(
		.MAX_SERVERS(MAX_SERVERS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_servers(num_q),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_head     (q_head),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

@@ dv/rrsd_checker.sv @@
// Dispatch checker: tracks server state from request beats and compares each result beat.
`timescale 1ns / 1ps

module rrsd_checker #(
	parameter int MAX_SERVERS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [rrsd_pkg::CFG_W-1:0] cfg_wdata,
	rrsd_req_if                             req,
	rrsd_rsp_if                             rsp,
	output int                              errors,
	output int                              pending,
	output int                              n_assign,
	output int                              n_drop,
	output int                              n_report
);
	import rrsd_pkg::*;

	logic [END_W-1:0]   busy_until [MAX_SERVERS];
	logic               busy       [MAX_SERVERS];
	logic [COUNT_W-1:0] served     [MAX_SERVERS];
	int                 next_start;
	logic [CFG_W-1:0]   server_cfg;
	res_t               dispatch_results[$];

	function automatic int active_servers();
		if (server_cfg == 0) return 1;
		if (server_cfg > MAX_SERVERS) return MAX_SERVERS;
		return int'(server_cfg);
	endfunction

	task automatic clear_servers();
		for (int i = 0; i < MAX_SERVERS; i++) begin
			busy_until[i] = '0;
			busy[i] = 1'b0;
			served[i] = '0;
		end
		next_start = 0;
	endtask

	task automatic push_result(input kind_t kind, input int idx, input logic [COUNT_W-1:0] count,
			input logic last_result);
		res_t r;
		r.kind = kind;
		r.server_index = SIDX_W'(idx);
		r.handled_count = count;
		r.last_result = last_result;
		dispatch_results.insert(dispatch_results.size(), r);
	endtask

	// Busiest-server report at the end of a batch, then wipe the batch state.
	task automatic report_busiest(input int k);
		logic [COUNT_W-1:0] top;
		top = '0;
		for (int i = 0; i < k; i++)
			if (served[i] > top) top = served[i];
		for (int i = 0; i < k; i++) begin
			if (served[i] == top) begin
				push_result(KIND_REPORT, i, top, 1'b0);
				n_report++;
			end
		end
		dispatch_results[dispatch_results.size() - 1].last_result = 1'b1;
		clear_servers();
	endtask

	task automatic dispatch_request(input logic [TIME_W-1:0] arrival,
			input logic [TIME_W-1:0] load, input logic is_last);
		int k, origin, pick, s;
		k = active_servers();
		// a pointer left beyond a shrunk pool restarts the search at server 0
		origin = (next_start < k) ? next_start : 0;
		pick = -1;
		for (int i = 0; i < k; i++)
			if (busy[i] && busy_until[i] <= {1'b0, arrival}) busy[i] = 1'b0;
		for (int i = 0; i < k; i++) begin
			s = (origin + i) % k;
			if (pick < 0 && !busy[s]) pick = s;
		end
		next_start = (origin + 1 >= k) ? 0 : origin + 1;
		if (pick >= 0) begin
			busy[pick] = 1'b1;
			busy_until[pick] = {1'b0, arrival} + {1'b0, load};
			if (served[pick] != '1) served[pick] = served[pick] + 1'b1;
			push_result(KIND_ASSIGN, pick, served[pick], !is_last);
			n_assign++;
		end else begin
			push_result(KIND_DROP, 0, '0, !is_last);
			n_drop++;
		end
		if (is_last) report_busiest(k);
	endtask

	task automatic compare_beat();
		res_t want;
		if (dispatch_results.size() == 0) begin
			errors++;
			$error("result beat with nothing outstanding: kind %0d server %0d count %0d",
				rsp.kind, rsp.server_index, rsp.handled_count);
			return;
		end
		want = dispatch_results.pop_front();
		if (rsp.kind !== want.kind) begin
			errors++;
			$error("kind: expected %0d, got %0d", want.kind, rsp.kind);
		end
		if (rsp.server_index !== want.server_index) begin
			errors++;
			$error("server_index: expected %0d, got %0d", want.server_index, rsp.server_index);
		end
		if (rsp.handled_count !== want.handled_count) begin
			errors++;
			$error("handled_count: expected %0d, got %0d", want.handled_count, rsp.handled_count);
		end
		if (rsp.last_result !== want.last_result) begin
			errors++;
			$error("last_result: expected %0d, got %0d", want.last_result, rsp.last_result);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_servers();
			server_cfg = NUM_SERVERS_RST;
			dispatch_results.delete();
		end else begin
			if (cfg_we) server_cfg = cfg_wdata;
			if (req.valid && req.ready)
				dispatch_request(req.arrival_time, req.load_time, req.last_request);
			if (rsp.valid && rsp.ready) compare_beat();
		end
		pending = dispatch_results.size();
	end

endmodule

@@ dv/tb.sv @@
// Testbench top: clock, reset, request and config stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps

module tb;
	import rrsd_pkg::*;

	localparam int MAX_SERVERS    = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_TAIL     = 2 * MAX_SERVERS + 4;
	localparam int RANDOM_PHASES  = 9;
	localparam int PHASE_ITEMS    = 39;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	rrsd_req_if req_ch();
	rrsd_rsp_if rsp_ch();

	int errors, pending, n_assign, n_drop, n_report;
	int idle_cycles, settings_used, requests_sent;
	bit no_gaps;
	logic [TIME_W-1:0] now;

	round_robin_server_dispatcher #(.MAX_SERVERS(MAX_SERVERS)) i_dut (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .req(req_ch), .rsp(rsp_ch)
	);

	rrsd_checker #(.MAX_SERVERS(MAX_SERVERS)) i_checker (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .req(req_ch), .rsp(rsp_ch),
		.errors, .pending, .n_assign, .n_drop, .n_report
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int next_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_gaps || roll < 65) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
				stall = next_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_request(input logic [TIME_W-1:0] arrival, input logic [TIME_W-1:0] load,
			input logic is_last);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.arrival_time <= arrival;
		req_ch.load_time <= load;
		req_ch.last_request <= is_last;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		requests_sent++;
	endtask

	// Hold off until every result is back and any report walk has settled.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_TAIL) @(negedge clk);
	endtask

	task automatic set_servers(input logic [CFG_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic run_random(input int count);
		int roll;
		logic [TIME_W:0] sum;
		logic [TIME_W-1:0] arrival, load, step;
		logic is_last;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				// out-of-order arrival; leave the batch clock alone
				arrival = now - TIME_W'($urandom_range(0, 50));
			end else begin
				if (roll < 92) step = $urandom_range(0, 8);
				else if (roll < 98) step = $urandom_range(9, 3000);
				else step = $urandom();
				sum = {1'b0, now} + {1'b0, step};
				now = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
				arrival = now;
			end
			roll = $urandom_range(0, 99);
			if (roll < 85) load = $urandom_range(1, 40);
			else if (roll < 95) load = $urandom_range(41, 2000);
			else load = $urandom();
			if (load == 0) load = 1;
			is_last = $urandom_range(0, 99) < 7;
			send_request(arrival, load, is_last);
			if (is_last) now = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1000);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] phase_cfg [RANDOM_PHASES];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.arrival_time = '0;
		req_ch.load_time = '0;
		req_ch.last_request = 1'b0;
		no_gaps = 1'b0;
		now = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset count of 16: time extremes and a 33-bit busy-until.
		send_request(32'd0, 32'd1, 1'b0);
		send_request(32'd0, '1, 1'b0);
		send_request('1, '1, 1'b0);
		send_request('1, 32'd1, 1'b1);

		// Four servers: fill the pool, drop, arrive out of order.
		set_servers(5'd4);
		repeat (3) send_request(32'd10, 32'd100, 1'b0);
		send_request(32'd20, 32'd5, 1'b0);
		send_request(32'd20, 32'd5, 1'b0);
		send_request(32'd5, 32'd1, 1'b0);
		send_request(32'd6, 32'd1, 1'b0);

		// Shrink below the pointer mid-batch, then end with a tied report.
		set_servers(5'd2);
		send_request(32'd200, 32'd1, 1'b0);
		send_request(32'd200, 32'd1, 1'b1);

		// Zero acts as one server.
		set_servers(5'd0);
		send_request(32'd0, 32'd1, 1'b0);
		send_request(32'd0, 32'd1, 1'b0);
		send_request(32'd1, 32'd1, 1'b1);

		// Above the maximum acts as the maximum.
		set_servers(5'd31);
		send_request(32'd50, 32'd300, 1'b0);
		send_request(32'd50, 32'd300, 1'b0);
		send_request(32'd60, 32'd7, 1'b0);
		send_request('1, 32'd1, 1'b1);

		phase_cfg = '{5'd1, 5'd16, 5'd5, 5'd3, 5'd0, 5'd12, 5'd7, 5'd2, 5'd31};
		phase_cfg[$urandom_range(0, RANDOM_PHASES - 1)] = CFG_W'($urandom_range(1, 16));
		now = $urandom_range(0, 1000);
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_servers(phase_cfg[p]);
			no_gaps = (p % 4) == 3;
			run_random(PHASE_ITEMS);
		end
		no_gaps = 1'b0;
		drain();

		$display("Run covered %0d requests across %0d server-count writes, with stalls on both sides",
			requests_sent, settings_used);
		$display("Result beats: %0d assigned, %0d dropped, %0d busiest-server reports",
			n_assign, n_drop, n_report);
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
